// ===== sv/bis_pkg.sv =====
`default_nettype none

package bis_pkg;

   localparam int COORD_W  = 12;
   localparam int DIM_W    = 13;
   localparam int CROP_W   = 27;
   localparam int LADDR_W  = 21;
   localparam int PIX_W    = 8;
   localparam int FRAC_MAX = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 27;
   // row * width + column needs up to 24 bits
   localparam int ASUM_W   = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_W     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_H     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT = 3'd7;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_REQ  = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [LADDR_W-1:0]   load_addr;
      logic [PIX_W-1:0]     load_pixel;
      logic [COORD_W-1:0]   out_col;
      logic [COORD_W-1:0]   out_row;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             clamped;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] src_width;
      logic [COORD_W-1:0] src_height;
      logic [CROP_W-1:0]  crop_x;
      logic [CROP_W-1:0]  crop_y;
      logic [CROP_W-1:0]  crop_w;
      logic [CROP_W-1:0]  crop_h;
      logic [DIM_W-1:0]   out_width;
      logic [DIM_W-1:0]   out_height;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0]  base;
      logic [COORD_W-1:0]  next;
      logic [FRAC_MAX-1:0] frac;
      logic                clamp;
   } axis_type;

   typedef struct packed {
      logic               is_req;
      logic [LADDR_W-1:0] load_addr;
      logic [PIX_W-1:0]   load_pixel;
      axis_type           x;
      axis_type           y;
   } map_type;

endpackage

`default_nettype wire

// ===== sv/bis_ram.sv =====
`default_nettype none

module bis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we_i,
   input  wire logic [AW-1:0]    waddr_i,
   input  wire logic [WIDTH-1:0] wdata_i,
   input  wire logic [AW-1:0]    raddr_a_i,
   input  wire logic [AW-1:0]    raddr_b_i,
   output logic      [WIDTH-1:0] rdata_a_o,
   output logic      [WIDTH-1:0] rdata_b_o
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we_i) begin
         mem[waddr_i] <= wdata_i;
      end
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
   end

endmodule

`default_nettype wire

// ===== sv/bis_fifo.sv =====
`default_nettype none

module bis_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_i,
   input  wire logic [WIDTH-1:0] data_i,
   input  wire logic             pop_i,
   output logic      [WIDTH-1:0] data_o,
   output logic                  empty_o,
   output logic                  full_o
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty_o = (count_ff == '0);
   assign full_o  = (count_ff == CNT_W'(DEPTH));
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;
   assign data_o  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_i;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o)
      else $error("queue push while full");
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count out of step");
`endif

endmodule

`default_nettype wire

// ===== sv/bis_front.sv =====
`default_nettype none

module bis_front #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bis_pkg::cfg_type  cfg_i,
   input  wire logic              in_valid_i,
   input  wire bis_pkg::req_type  in_item_i,
   output logic                   out_valid_o,
   output bis_pkg::map_type       out_item_o
);

   localparam int PW   = bis_pkg::CROP_W + bis_pkg::COORD_W;
   localparam int DIVW = bis_pkg::DIM_W;
   localparam int CW   = bis_pkg::COORD_W;

   function automatic bis_pkg::axis_type map_axis(
      input logic [bis_pkg::CROP_W-1:0] origin,
      input logic [PW-1:0]              quot,
      input logic [CW-1:0]              limit
   );
      logic [PW:0]           pos;
      logic [PW-FRAC_BITS:0] base;
      logic [CW-1:0]         last;
      bis_pkg::axis_type     r;
      pos     = {1'b0, quot} + (PW + 1)'(origin);
      base    = pos[PW:FRAC_BITS];
      last    = ((limit == '0) ? CW'(1) : limit) - CW'(1);
      r.clamp = base > (PW - FRAC_BITS + 1)'(last);
      r.base  = r.clamp ? last : base[CW-1:0];
      r.frac  = r.clamp ? '0 : bis_pkg::FRAC_MAX'(pos[FRAC_BITS-1:0]);
      r.next  = (r.base == last) ? last : r.base + CW'(1);
      return r;
   endfunction

   logic [DIVW-1:0] xdiv, ydiv;
   assign xdiv = (cfg_i.out_width == '0) ? DIVW'(1) : cfg_i.out_width;
   assign ydiv = (cfg_i.out_height == '0) ? DIVW'(1) : cfg_i.out_height;

   // product stage
   logic             s1_valid_ff;
   bis_pkg::req_type s1_item_ff;
   logic [PW-1:0]    s1_px_ff, s1_py_ff, s1_px_in, s1_py_in;

   assign s1_px_in = PW'(cfg_i.crop_w) * PW'(in_item_i.out_col);
   assign s1_py_in = PW'(cfg_i.crop_h) * PW'(in_item_i.out_row);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid_i;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= in_item_i;
      s1_px_ff   <= s1_px_in;
      s1_py_ff   <= s1_py_in;
   end

   // restoring divider, one quotient bit per stage
   logic             dv_ff    [PW];
   bis_pkg::req_type dreq_ff  [PW];
   logic [DIVW-1:0]  xrem_ff  [PW];
   logic [DIVW-1:0]  yrem_ff  [PW];
   logic [PW-1:0]    xwork_ff [PW];
   logic [PW-1:0]    ywork_ff [PW];

   for (genvar k = 0; k < PW; k++) begin : g_div
      logic             v_src;
      bis_pkg::req_type r_src;
      logic [DIVW-1:0]  xr_src, yr_src, xr_in, yr_in;
      logic [PW-1:0]    xw_src, yw_src;
      logic [DIVW:0]    xt, yt;
      logic             xge, yge;

      if (k == 0) begin : g_first
         assign v_src  = s1_valid_ff;
         assign r_src  = s1_item_ff;
         assign xr_src = '0;
         assign yr_src = '0;
         assign xw_src = s1_px_ff;
         assign yw_src = s1_py_ff;
      end else begin : g_next
         assign v_src  = dv_ff[k-1];
         assign r_src  = dreq_ff[k-1];
         assign xr_src = xrem_ff[k-1];
         assign yr_src = yrem_ff[k-1];
         assign xw_src = xwork_ff[k-1];
         assign yw_src = ywork_ff[k-1];
      end

      assign xt    = {xr_src, xw_src[PW-1]};
      assign yt    = {yr_src, yw_src[PW-1]};
      assign xge   = xt >= {1'b0, xdiv};
      assign yge   = yt >= {1'b0, ydiv};
      assign xr_in = xge ? DIVW'(xt - {1'b0, xdiv}) : DIVW'(xt);
      assign yr_in = yge ? DIVW'(yt - {1'b0, ydiv}) : DIVW'(yt);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else begin
            dv_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         dreq_ff[k]  <= r_src;
         xrem_ff[k]  <= xr_in;
         yrem_ff[k]  <= yr_in;
         xwork_ff[k] <= {xw_src[PW-2:0], xge};
         ywork_ff[k] <= {yw_src[PW-2:0], yge};
      end
   end

   // window mapping and edge clamp
   logic             map_valid_ff;
   bis_pkg::map_type map_item_ff, map_item_in;

   always_comb begin
      map_item_in.is_req     = (dreq_ff[PW-1].kind == bis_pkg::KIND_REQ);
      map_item_in.load_addr  = dreq_ff[PW-1].load_addr;
      map_item_in.load_pixel = dreq_ff[PW-1].load_pixel;
      map_item_in.x = map_axis(cfg_i.crop_x, xwork_ff[PW-1], cfg_i.src_width);
      map_item_in.y = map_axis(cfg_i.crop_y, ywork_ff[PW-1], cfg_i.src_height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
      end else begin
         map_valid_ff <= dv_ff[PW-1];
      end
   end

   always_ff @(posedge clock) begin
      map_item_ff <= map_item_in;
   end

   assign out_valid_o = map_valid_ff;
   assign out_item_o  = map_item_ff;

`ifndef ASSERT_OFF
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid_i |-> ##(PW + 2) out_valid_o)
      else $error("front lost a transaction");
`endif

endmodule

`default_nettype wire

// ===== sv/bis_back.sv =====
`default_nettype none

module bis_back #(
   parameter int FRAME_PIXELS = 2097152,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bis_pkg::cfg_type  cfg_i,
   input  wire logic              head_valid_i,
   input  wire bis_pkg::map_type  head_item_i,
   output logic                   pop_o,
   output logic                   rsp_valid_o,
   output bis_pkg::rsp_type       rsp_item_o
);

   localparam int AW   = $clog2(FRAME_PIXELS);
   localparam int PAW  = bis_pkg::ASUM_W;
   localparam int NS   = PAW - AW + 1;
   localparam int CW   = bis_pkg::COORD_W;
   localparam int RBW  = 2 * CW;
   localparam int PXW  = bis_pkg::PIX_W;
   localparam int WW   = FRAC_BITS + 1;
   localparam int HW   = PXW + FRAC_BITS + 1;
   localparam int VW   = HW + FRAC_BITS + 1;
   localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

   assign pop_o = head_valid_i;

   // row base products
   logic             a_valid_ff;
   bis_pkg::map_type a_item_ff;
   logic [RBW-1:0]   a_rb0_ff, a_rb1_ff;
   logic [CW-1:0]    stride;

   assign stride = (cfg_i.src_width == '0) ? CW'(1) : cfg_i.src_width;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= head_valid_i;
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff <= head_item_i;
      a_rb0_ff  <= RBW'(head_item_i.y.base) * RBW'(stride);
      a_rb1_ff  <= RBW'(head_item_i.y.next) * RBW'(stride);
   end

   // four neighbour addresses: base, next column, next row, diagonal
   logic             b_valid_ff;
   bis_pkg::map_type b_item_ff;
   logic [PAW-1:0]   b_addr_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_item_ff    <= a_item_ff;
      b_addr_ff[0] <= PAW'(a_rb0_ff) + PAW'(a_item_ff.x.base);
      b_addr_ff[1] <= PAW'(a_rb0_ff) + PAW'(a_item_ff.x.next);
      b_addr_ff[2] <= PAW'(a_rb1_ff) + PAW'(a_item_ff.x.base);
      b_addr_ff[3] <= PAW'(a_rb1_ff) + PAW'(a_item_ff.x.next);
   end

   // wrap addresses into the store: subtract shifted store size, high bit first
   logic             m_valid_ff [NS];
   bis_pkg::map_type m_item_ff  [NS];
   logic [PAW-1:0]   m_addr_ff  [NS][4];

   for (genvar k = 0; k < NS; k++) begin : g_mod
      localparam logic [PAW:0] SUB = (PAW + 1)'(FRAME_PIXELS) << (NS - 1 - k);
      logic             v_src;
      bis_pkg::map_type i_src;
      logic [PAW-1:0]   a_src [4];

      if (k == 0) begin : g_first
         assign v_src = b_valid_ff;
         assign i_src = b_item_ff;
         for (genvar j = 0; j < 4; j++) begin : g_a
            assign a_src[j] = b_addr_ff[j];
         end
      end else begin : g_next
         assign v_src = m_valid_ff[k-1];
         assign i_src = m_item_ff[k-1];
         for (genvar j = 0; j < 4; j++) begin : g_a
            assign a_src[j] = m_addr_ff[k-1][j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            m_valid_ff[k] <= 1'b0;
         end else begin
            m_valid_ff[k] <= v_src;
         end
      end

      for (genvar j = 0; j < 4; j++) begin : g_sub
         logic [PAW:0] t;
         assign t = {1'b0, a_src[j]};
         always_ff @(posedge clock) begin
            m_addr_ff[k][j] <= (t >= SUB) ? PAW'(t - SUB) : a_src[j];
         end
      end

      always_ff @(posedge clock) begin
         m_item_ff[k] <= i_src;
      end
   end

   // frame store, two copies so four pixels come out each cycle
   bis_pkg::map_type f_item;
   logic             f_valid, f_we;
   logic [AW-1:0]    f_waddr;
   logic [PXW-1:0]   p00, p01, p10, p11;

   assign f_item  = m_item_ff[NS-1];
   assign f_valid = m_valid_ff[NS-1];
   assign f_we    = f_valid && !f_item.is_req &&
                    ((PAW + 1)'(f_item.load_addr) < (PAW + 1)'(FRAME_PIXELS));
   assign f_waddr = AW'(f_item.load_addr);

   bis_ram #(.WIDTH(PXW), .DEPTH(FRAME_PIXELS)) u_ram_row0 (
      .clock     (clock),
      .we_i      (f_we),
      .waddr_i   (f_waddr),
      .wdata_i   (f_item.load_pixel),
      .raddr_a_i (m_addr_ff[NS-1][0][AW-1:0]),
      .raddr_b_i (m_addr_ff[NS-1][1][AW-1:0]),
      .rdata_a_o (p00),
      .rdata_b_o (p01)
   );

   bis_ram #(.WIDTH(PXW), .DEPTH(FRAME_PIXELS)) u_ram_row1 (
      .clock     (clock),
      .we_i      (f_we),
      .waddr_i   (f_waddr),
      .wdata_i   (f_item.load_pixel),
      .raddr_a_i (m_addr_ff[NS-1][2][AW-1:0]),
      .raddr_b_i (m_addr_ff[NS-1][3][AW-1:0]),
      .rdata_a_o (p10),
      .rdata_b_o (p11)
   );

   logic             r_valid_ff;
   bis_pkg::map_type r_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= f_valid && f_item.is_req;
      end
   end

   always_ff @(posedge clock) begin
      r_item_ff <= f_item;
   end

   // horizontal blend
   logic [WW-1:0] fx, fy;
   logic          h_valid_ff;
   logic [HW-1:0] h0_ff, h1_ff;
   logic [WW-1:0] h_fy_ff;
   logic          h_clamp_ff;

   assign fx = WW'(r_item_ff.x.frac[FRAC_BITS-1:0]);
   assign fy = WW'(r_item_ff.y.frac[FRAC_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      h0_ff      <= HW'(p00) * HW'(ONE - fx) + HW'(p01) * HW'(fx);
      h1_ff      <= HW'(p10) * HW'(ONE - fx) + HW'(p11) * HW'(fx);
      h_fy_ff    <= fy;
      h_clamp_ff <= r_item_ff.x.clamp || r_item_ff.y.clamp;
   end

   // vertical blend and output register
   logic             rsp_valid_ff;
   bis_pkg::rsp_type rsp_item_ff;
   logic [VW-1:0]    vsum;

   assign vsum = VW'(h0_ff) * VW'(ONE - h_fy_ff) + VW'(h1_ff) * VW'(h_fy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff.pixel   <= vsum[2*FRAC_BITS +: PXW];
      rsp_item_ff.clamped <= h_clamp_ff;
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_item_o  = rsp_item_ff;

`ifndef ASSERT_OFF
   a_addr_wrapped: assert property (@(posedge clock) disable iff (reset)
      f_valid |-> (m_addr_ff[NS-1][0] < PAW'(FRAME_PIXELS)) &&
                  (m_addr_ff[NS-1][3] < PAW'(FRAME_PIXELS)))
      else $error("neighbour address not wrapped into store");
   a_blend_range: assert property (@(posedge clock) disable iff (reset)
      h_valid_ff |-> (h0_ff < (HW'(1) << (PXW + FRAC_BITS))) &&
                     (h1_ff < (HW'(1) << (PXW + FRAC_BITS))))
      else $error("horizontal blend out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/bilinear_image_scaler.sv =====
// Bilinear image scaler, 8-bit grey.
// Input channel: start with req_item. A transaction is taken at a clock edge
// with start high and busy low. kind = load writes load_pixel into the frame
// store at load_addr; kind = request asks for the pixel at out_col/out_row.
// Result channel: rsp_valid strobes for one cycle with rsp_item (pixel,
// clamped), one result per request, none per load, in request order.
// The receiver cannot stall; results must be taken when strobed.
// Configuration: csr_we writes csr_wdata into register csr_index at the edge.
// Write only while no transaction is in flight.
// Throughput: one transaction per clock. busy rises only if the queue
// between mapping and fetch fills, which never happens: the back end pops it
// every cycle.
// Path from the accepting edge to the result strobe: the product stage, the
// 39-stage restoring divider for the window mapping, then queue, row
// multiply, address sum, address wrap, store read, two blends.
// Reset clears control and loads register defaults; the frame store is
// undefined until loaded, and needs no clearing pass.
`default_nettype none

module bilinear_image_scaler #(
   parameter int FRAME_PIXELS = 2097152,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire bis_pkg::req_type                   req_item,
   output logic                                    rsp_valid,
   output bis_pkg::rsp_type                        rsp_item,
   input  wire logic                               csr_we,
   input  wire logic [bis_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bis_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int QW = $bits(bis_pkg::map_type);

   bis_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= 12'd1920;
         cfg_ff.src_height <= 12'd1080;
         cfg_ff.crop_x     <= 27'd24936448;
         cfg_ff.crop_y     <= 27'd17707827;
         cfg_ff.crop_w     <= 27'd62914560;
         cfg_ff.crop_h     <= 27'd35337011;
         cfg_ff.out_width  <= 13'd1920;
         cfg_ff.out_height <= 13'd1080;
      end else if (csr_we) begin
         unique case (csr_index)
            bis_pkg::CSR_SRC_WIDTH:  cfg_ff.src_width  <= csr_wdata[11:0];
            bis_pkg::CSR_SRC_HEIGHT: cfg_ff.src_height <= csr_wdata[11:0];
            bis_pkg::CSR_CROP_X:     cfg_ff.crop_x     <= csr_wdata;
            bis_pkg::CSR_CROP_Y:     cfg_ff.crop_y     <= csr_wdata;
            bis_pkg::CSR_CROP_W:     cfg_ff.crop_w     <= csr_wdata;
            bis_pkg::CSR_CROP_H:     cfg_ff.crop_h     <= csr_wdata;
            bis_pkg::CSR_OUT_WIDTH:  cfg_ff.out_width  <= csr_wdata[12:0];
            bis_pkg::CSR_OUT_HEIGHT: cfg_ff.out_height <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   logic             accept;
   logic             map_valid;
   bis_pkg::map_type map_item, head_item;
   logic             q_empty, q_full, q_pop;

   assign busy   = q_full;
   assign accept = start && !busy;

   bis_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg_i       (cfg_ff),
      .in_valid_i  (accept),
      .in_item_i   (req_item),
      .out_valid_o (map_valid),
      .out_item_o  (map_item)
   );

   bis_fifo #(.WIDTH(QW), .DEPTH(4)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (map_valid),
      .data_i  (map_item),
      .pop_i   (q_pop),
      .data_o  (head_item),
      .empty_o (q_empty),
      .full_o  (q_full)
   );

   bis_back #(.FRAME_PIXELS(FRAME_PIXELS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg_i        (cfg_ff),
      .head_valid_i (!q_empty),
      .head_item_i  (head_item),
      .pop_o        (q_pop),
      .rsp_valid_o  (rsp_valid),
      .rsp_item_o   (rsp_item)
   );

endmodule

`default_nettype wire

// ===== dv/tb_bilinear_image_scaler.sv =====
`timescale 1ns / 100ps

module tb_bilinear_image_scaler;

   localparam int unsigned STORE_DEPTH = 2097152;
   localparam int unsigned FRAC = 16;
   localparam int unsigned DRAIN_CYCLES = 80;
   localparam int unsigned CYCLE_LIMIT = 1500000;

   class pixel_scoreboard;
      byte unsigned frame[int unsigned];
      longint unsigned regs[8];
      bis_pkg::rsp_type pending_pixels[$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned clamp_hits;

      function void reset_regs();
         regs = '{1920, 1080, 24936448, 17707827, 62914560, 35337011, 1920, 1080};
      endfunction

      function void write_reg(logic [bis_pkg::CSR_IDX_W-1:0] idx,
                              logic [bis_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            bis_pkg::CSR_SRC_WIDTH, bis_pkg::CSR_SRC_HEIGHT: regs[idx] = val[11:0];
            bis_pkg::CSR_OUT_WIDTH, bis_pkg::CSR_OUT_HEIGHT: regs[idx] = val[12:0];
            default: regs[idx] = val;
         endcase
      endfunction

      function longint unsigned nz(longint unsigned v);
         return (v == 0) ? 1 : v;
      endfunction

      function void map_axis(longint unsigned origin, longint unsigned size,
                             longint unsigned d, longint unsigned dim,
                             longint unsigned lim, output longint unsigned base,
                             output longint unsigned nxt, output longint unsigned frac,
                             inout bit clp);
         longint unsigned pos, last;
         pos = origin + (size * d) / nz(dim);
         base = pos >> FRAC;
         last = nz(lim) - 1;
         frac = pos & 64'hFFFF;
         if (base > last) begin
            base = last;
            frac = 0;
            clp = 1;
         end
         nxt = (base + 1 > last) ? last : base + 1;
      endfunction

      // four neighbour addresses: base, next column, next row, diagonal
      function void taps(logic [bis_pkg::COORD_W-1:0] col, logic [bis_pkg::COORD_W-1:0] row,
                         output int unsigned addr[4], output longint unsigned fx,
                         output longint unsigned fy, output bit clp);
         longint unsigned x0, x1, y0, y1, w;
         clp = 0;
         map_axis(regs[bis_pkg::CSR_CROP_X], regs[bis_pkg::CSR_CROP_W], col,
                  regs[bis_pkg::CSR_OUT_WIDTH], regs[bis_pkg::CSR_SRC_WIDTH],
                  x0, x1, fx, clp);
         map_axis(regs[bis_pkg::CSR_CROP_Y], regs[bis_pkg::CSR_CROP_H], row,
                  regs[bis_pkg::CSR_OUT_HEIGHT], regs[bis_pkg::CSR_SRC_HEIGHT],
                  y0, y1, fy, clp);
         w = nz(regs[bis_pkg::CSR_SRC_WIDTH]);
         addr[0] = 32'((y0 * w + x0) % STORE_DEPTH);
         addr[1] = 32'((y0 * w + x1) % STORE_DEPTH);
         addr[2] = 32'((y1 * w + x0) % STORE_DEPTH);
         addr[3] = 32'((y1 * w + x1) % STORE_DEPTH);
      endfunction

      function longint unsigned texel(int unsigned a);
         return frame.exists(a) ? frame[a] : 0;
      endfunction

      function bis_pkg::rsp_type blend(logic [bis_pkg::COORD_W-1:0] col,
                                       logic [bis_pkg::COORD_W-1:0] row);
         int unsigned addr[4];
         longint unsigned fx, fy, one, total;
         bit clp;
         bis_pkg::rsp_type r;
         one = 64'd1 << FRAC;
         taps(col, row, addr, fx, fy, clp);
         total = texel(addr[0]) * (one - fx) * (one - fy)
               + texel(addr[1]) * fx * (one - fy)
               + texel(addr[2]) * (one - fx) * fy
               + texel(addr[3]) * fx * fy;
         r.pixel = 8'(total >> (2 * FRAC));
         r.clamped = clp;
         return r;
      endfunction

      function void note_item(bis_pkg::req_type item);
         if (item.kind == bis_pkg::KIND_LOAD)
            frame[item.load_addr] = item.load_pixel;
         else
            pending_pixels.push_back(blend(item.out_col, item.out_row));
      endfunction

      function void check_pixel(bis_pkg::rsp_type got);
         bis_pkg::rsp_type want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result pixel=%0d clamped=%0b",
                        got.pixel, got.clamped);
            return;
         end
         want = pending_pixels.pop_front();
         checked++;
         if (got.clamped) clamp_hits++;
         if (got.pixel !== want.pixel || got.clamped !== want.clamped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d exp pixel=%0d clamped=%0b got pixel=%0d clamped=%0b",
                        checked, want.pixel, want.clamped, got.pixel, got.clamped);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   bis_pkg::req_type req_item;
   logic rsp_valid;
   bis_pkg::rsp_type rsp_item;
   logic csr_we;
   logic [bis_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bis_pkg::CSR_DATA_W-1:0] csr_wdata;

   pixel_scoreboard sb;
   bit written[int unsigned];
   bit idle_on;
   int unsigned cycles;
   int unsigned req_count;
   int unsigned load_count;
   int unsigned phase_count;

   bilinear_image_scaler u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.note_item(req_item);
         if (rsp_valid) sb.check_pixel(rsp_item);
      end
   end

   task automatic send(bis_pkg::req_type item);
      while (idle_on && $urandom_range(99) < 22) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic load_pixel(int unsigned addr, logic [7:0] value);
      bis_pkg::req_type item;
      item.kind = bis_pkg::KIND_LOAD;
      item.load_addr = 21'(addr);
      item.load_pixel = value;
      item.out_col = 12'($urandom);
      item.out_row = 12'($urandom);
      written[addr] = 1;
      load_count++;
      send(item);
   endtask

   // loads any neighbour the block has not seen yet, then issues the request
   task automatic request_pixel(logic [bis_pkg::COORD_W-1:0] col,
                                logic [bis_pkg::COORD_W-1:0] row);
      bis_pkg::req_type item;
      int unsigned addr[4];
      longint unsigned fx, fy;
      bit clp;
      sb.taps(col, row, addr, fx, fy, clp);
      foreach (addr[i])
         if (!written.exists(addr[i])) load_pixel(addr[i], 8'($urandom));
      item.kind = bis_pkg::KIND_REQ;
      item.load_addr = 21'($urandom);
      item.load_pixel = 8'($urandom);
      item.out_col = col;
      item.out_row = row;
      req_count++;
      send(item);
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(longint unsigned vals[8]);
      foreach (vals[i]) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= bis_pkg::CSR_IDX_W'(i);
         csr_wdata <= bis_pkg::CSR_DATA_W'(vals[i]);
      end
      @(negedge clock);
      csr_we <= 1'b0;
      phase_count++;
   endtask

   task automatic random_requests(int unsigned n, int unsigned span_c, int unsigned span_r);
      for (int unsigned k = 0; k < n; k++) begin
         if ($urandom_range(99) < 15)
            load_pixel($urandom_range(STORE_DEPTH - 1), 8'($urandom));
         else if ($urandom_range(99) < 10)
            request_pixel(12'($urandom), 12'($urandom));
         else
            request_pixel(12'($urandom_range(span_c)), 12'($urandom_range(span_r)));
      end
   endtask

   initial begin
      longint unsigned vals[8];
      longint unsigned sw, shh;
      sb = new();
      start = 0;
      req_item = '0;
      csr_we = 0;
      csr_index = bis_pkg::CSR_SRC_WIDTH;
      csr_wdata = '0;
      cycles = 0;
      idle_on = 1;
      reset = 1;
      sb.reset_regs();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // defaults: corners, edges and loads at both ends of the address range
      request_pixel(12'd0, 12'd0);
      request_pixel(12'd4095, 12'd4095);
      request_pixel(12'd1919, 12'd1079);
      request_pixel(12'd0, 12'd4095);
      request_pixel(12'd4095, 12'd0);
      request_pixel(12'd960, 12'd539);
      load_pixel(STORE_DEPTH - 1, 8'hFF);
      load_pixel(0, 8'h00);
      random_requests(75, 1920, 1080);
      settle();

      // extremes: largest source so neighbour addresses wrap, widest window
      vals = '{4095, 4095, 134217727, 134217727, 134217727, 134217727, 1, 1};
      set_regs(vals);
      request_pixel(12'd0, 12'd0);
      request_pixel(12'd4095, 12'd4095);
      random_requests(20, 4095, 4095);
      settle();

      vals = '{2048, 2048, 0, 0, 134217727, 134217727, 8191, 8191};
      set_regs(vals);
      request_pixel(12'd4095, 12'd4095);
      request_pixel(12'd0, 12'd4095);
      random_requests(30, 4095, 4095);
      settle();

      // zero source and output dimension registers are taken as one
      vals = '{0, 0, 0, 0, 0, 0, 0, 0};
      set_regs(vals);
      request_pixel(12'd0, 12'd0);
      request_pixel(12'd4095, 12'd4095);
      random_requests(10, 4095, 4095);
      settle();

      // 1:1 pixel grid with half-pixel fractions, back to back
      idle_on = 0;
      vals = '{8, 8, 32768, 32768, 8 << 16, 8 << 16, 8, 8};
      set_regs(vals);
      random_requests(100, 9, 9);
      settle();
      idle_on = 1;

      for (int p = 0; p < 10; p++) begin
         sw = ($urandom_range(9) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 16);
         shh = ($urandom_range(9) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 16);
         vals[bis_pkg::CSR_SRC_WIDTH] = sw;
         vals[bis_pkg::CSR_SRC_HEIGHT] = shh;
         vals[bis_pkg::CSR_CROP_X] = $urandom_range(0, 32'((sw << 16) - 1));
         vals[bis_pkg::CSR_CROP_Y] = $urandom_range(0, 32'((shh << 16) - 1));
         vals[bis_pkg::CSR_CROP_W] = $urandom_range(0, 32'((sw + 2) << 16)) & 27'h7FFFFFF;
         vals[bis_pkg::CSR_CROP_H] = $urandom_range(0, 32'((shh + 2) << 16)) & 27'h7FFFFFF;
         vals[bis_pkg::CSR_OUT_WIDTH] = $urandom_range(1, 64);
         vals[bis_pkg::CSR_OUT_HEIGHT] = $urandom_range(1, 64);
         set_regs(vals);
         random_requests(50, 32'(vals[bis_pkg::CSR_OUT_WIDTH] + 2),
                         32'(vals[bis_pkg::CSR_OUT_HEIGHT] + 2));
         settle();
      end

      $display("Ran %0d requests and %0d loads over %0d register settings", req_count,
               load_count, phase_count + 1);
      $display("Checked %0d pixels, %0d with clamped base", sb.checked, sb.clamp_hits);
      if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
